// ===== hdl/dcd_pkg.sv =====
// ----------------------------------------------------------------------------
// dcd_pkg
// Shared widths and codes for the directed cycle detector.
// ----------------------------------------------------------------------------
package dcd_pkg;

  localparam int VID_W    = 6;
  localparam int VCOUNT_W = 7;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

endpackage

// ===== hdl/directed_cycle_detect_top.sv =====
// ----------------------------------------------------------------------------
// directed_cycle_detect_top
// Directed graph cycle detector: edges load into an adjacency RAM, evaluate
// runs a stack-based depth-first walk and reports whether a cycle exists.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): action_i = add selects an edge
//   load from from_vertex_i to to_vertex_i; action_i = evaluate runs the walk
//   over vertices below vertex_count and then empties the graph.
//   Edge loads are taken one per cycle while idle, back to back; an edge
//   whose endpoint is at or above MAX_VERTICES is dropped. They give no result.
//   Evaluate holds in_stall_o high while the walk runs. Each walk step is an
//   adjacency RAM read (ST_ROW_RD) followed by an evaluate (ST_ROW_EVAL); a
//   cycle found early ends the walk sooner. Matrix and marks are emptied
//   together at the end, in ST_DONE.
//   Output channel (out_valid_o / out_stall_i): one has_cycle_o item per
//   evaluate, held in an output register; edges are still taken while it
//   waits. A new evaluate may run, but finishes only once the previous
//   result has been taken.
//   cfg_we_i writes vertex_count (cfg_wdata_i); the user keeps it to idle.
//   Reset: empty graph, vertex_count = 64, no result pending.
// ----------------------------------------------------------------------------
module directed_cycle_detect_top #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dcd_pkg::VCOUNT_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [dcd_pkg::VID_W-1:0]     from_vertex_i,
  input  logic [dcd_pkg::VID_W-1:0]     to_vertex_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          has_cycle_o
);

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int EW = (VW > dcd_pkg::VID_W) ? VW : dcd_pkg::VID_W;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SCAN     = 3'd1;
  localparam logic [2:0] ST_ROW_RD   = 3'd2;
  localparam logic [2:0] ST_ROW_EVAL = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;

  typedef logic [MAX_VERTICES-1:0] row_t;
  typedef logic [VW-1:0]           vid_t;

  // adjacency RAM and stack RAM
  row_t adj_mem [MAX_VERTICES];
  vid_t stk_mem [MAX_VERTICES];

  logic                       adj_we;
  vid_t                       adj_waddr;
  row_t                       adj_wdata;
  vid_t                       adj_raddr;
  row_t                       adj_rdata_q;
  logic                       rd_vld_q;

  logic                       stk_we;
  vid_t                       stk_waddr;
  vid_t                       stk_wdata;
  vid_t                       stk_raddr;
  logic [NW-1:0]              stk_raddr_full;
  vid_t                       stk_rdata_q;

  logic [2:0]                 state_q, state_d;
  logic [dcd_pkg::VCOUNT_W-1:0] vcount_q, vcount_d;
  row_t                       row_valid_q, row_valid_d;
  row_t                       visited_q, visited_d;
  row_t                       onpath_q, onpath_d;
  row_t                       mask_q, mask_d;
  logic [NW-1:0]              n_q, n_d;
  logic [NW-1:0]              s_q, s_d;
  logic [NW-1:0]              depth_q, depth_d;
  vid_t                       top_q, top_d;
  logic                       cyc_q, cyc_d;
  logic                       out_valid_q, out_valid_d;
  logic                       has_cycle_q, has_cycle_d;

  logic                       s1_vld_q, s1_vld_d;
  vid_t                       s1_row_q, s1_row_d;
  vid_t                       s1_col_q, s1_col_d;
  logic                       last_vld_q;
  vid_t                       last_row_q;
  row_t                       last_data_q;

  logic [EW-1:0]              from_ext;
  logic [EW-1:0]              to_ext;
  logic                       in_acc;
  logic                       edge_ok;
  logic [NW-1:0]              n_eff;
  row_t                       edge_base;
  row_t                       row_eff;
  row_t                       cand;
  logic                       hit;
  logic                       have_next;
  vid_t                       next_v;
  vid_t                       scan_v;

  assign from_ext = EW'(from_vertex_i);
  assign to_ext   = EW'(to_vertex_i);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign edge_ok  = (int'(from_vertex_i) < MAX_VERTICES) && (int'(to_vertex_i) < MAX_VERTICES);
  assign n_eff    = (int'(vcount_q) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vcount_q);
  assign scan_v   = s_q[VW-1:0];

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign has_cycle_o = has_cycle_q;

  // edge read-modify-write with forwarding of the previous write
  assign edge_base = (last_vld_q && (last_row_q == s1_row_q)) ? last_data_q :
                     (rd_vld_q ? adj_rdata_q : '0);
  assign adj_we    = s1_vld_q;
  assign adj_waddr = s1_row_q;
  always_comb begin
    adj_wdata = edge_base;
    adj_wdata[s1_col_q] = 1'b1;
  end
  assign adj_raddr = (state_q == ST_IDLE) ? from_ext[VW-1:0] : top_q;

  assign stk_raddr_full = depth_q - NW'(2);
  assign stk_raddr      = stk_raddr_full[VW-1:0];

  // walk step on the row of the top vertex
  assign row_eff   = (rd_vld_q ? adj_rdata_q : '0) & mask_q;
  assign hit       = |(row_eff & onpath_q);
  assign cand      = row_eff & ~visited_q;
  assign have_next = |cand;
  always_comb begin
    next_v = '0;
    for (int u = MAX_VERTICES - 1; u >= 0; u--) begin
      if (cand[u]) begin
        next_v = VW'(u);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    vcount_d    = vcount_q;
    row_valid_d = row_valid_q;
    visited_d   = visited_q;
    onpath_d    = onpath_q;
    mask_d      = mask_q;
    n_d         = n_q;
    s_d         = s_q;
    depth_d     = depth_q;
    top_d       = top_q;
    cyc_d       = cyc_q;
    out_valid_d = out_valid_q && out_stall_i;
    has_cycle_d = has_cycle_q;
    s1_vld_d    = 1'b0;
    s1_row_d    = from_ext[VW-1:0];
    s1_col_d    = to_ext[VW-1:0];
    stk_we      = 1'b0;
    stk_waddr   = depth_q[VW-1:0];
    stk_wdata   = scan_v;

    if (cfg_we_i) begin
      vcount_d = cfg_wdata_i;
    end
    if (s1_vld_q) begin
      row_valid_d[s1_row_q] = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (action_i == dcd_pkg::ACT_EVAL) begin
            n_d   = n_eff;
            s_d   = '0;
            cyc_d = 1'b0;
            for (int u = 0; u < MAX_VERTICES; u++) begin
              mask_d[u] = (NW'(u) < n_eff);
            end
            state_d = ST_SCAN;
          end else begin
            s1_vld_d = edge_ok;
          end
        end
      end
      ST_SCAN: begin
        if (s_q >= n_q) begin
          state_d = ST_DONE;
        end else begin
          s_d = s_q + NW'(1);
          if (!visited_q[scan_v]) begin
            stk_we            = 1'b1;
            stk_wdata         = scan_v;
            depth_d           = depth_q + NW'(1);
            visited_d[scan_v] = 1'b1;
            onpath_d[scan_v]  = 1'b1;
            top_d             = scan_v;
            state_d           = ST_ROW_RD;
          end
        end
      end
      ST_ROW_RD: begin
        state_d = ST_ROW_EVAL;
      end
      ST_ROW_EVAL: begin
        if (hit) begin
          cyc_d   = 1'b1;
          state_d = ST_DONE;
        end else if (have_next) begin
          stk_we            = 1'b1;
          stk_wdata         = next_v;
          depth_d           = depth_q + NW'(1);
          visited_d[next_v] = 1'b1;
          onpath_d[next_v]  = 1'b1;
          top_d             = next_v;
          state_d           = ST_ROW_RD;
        end else begin
          onpath_d[top_q] = 1'b0;
          depth_d         = depth_q - NW'(1);
          if (depth_q == NW'(1)) begin
            state_d = ST_SCAN;
          end else begin
            top_d   = stk_rdata_q;
            state_d = ST_ROW_RD;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          has_cycle_d = cyc_q;
          row_valid_d = '0;
          visited_d   = '0;
          onpath_d    = '0;
          depth_d     = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    adj_rdata_q <= adj_mem[adj_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vcount_q    <= dcd_pkg::VCOUNT_RESET;
      row_valid_q <= '0;
      visited_q   <= '0;
      onpath_q    <= '0;
      mask_q      <= '0;
      n_q         <= '0;
      s_q         <= '0;
      depth_q     <= '0;
      cyc_q       <= 1'b0;
      out_valid_q <= 1'b0;
      s1_vld_q    <= 1'b0;
      last_vld_q  <= 1'b0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      vcount_q    <= vcount_d;
      row_valid_q <= row_valid_d;
      visited_q   <= visited_d;
      onpath_q    <= onpath_d;
      mask_q      <= mask_d;
      n_q         <= n_d;
      s_q         <= s_d;
      depth_q     <= depth_d;
      cyc_q       <= cyc_d;
      out_valid_q <= out_valid_d;
      s1_vld_q    <= s1_vld_d;
      last_vld_q  <= s1_vld_q;
      rd_vld_q    <= row_valid_q[adj_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    top_q       <= top_d;
    has_cycle_q <= has_cycle_d;
    s1_row_q    <= s1_row_d;
    s1_col_q    <= s1_col_d;
    last_row_q  <= s1_row_q;
    last_data_q <= adj_wdata;
  end

endmodule

// ===== hdl/dcd_checker.sv =====
// ----------------------------------------------------------------------------
// dcd_checker
// Port-level checks for the directed cycle detector, bound to the top level.
// ----------------------------------------------------------------------------
module dcd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          action_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          has_cycle_o
);

  // evaluate item makes the block busy
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i == dcd_pkg::ACT_EVAL) |=> in_stall_o)
    else $error("evaluate item accepted but block not busy");

  // a result only appears at the end of a busy walk
  a_result_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a walk");

  // an edge load never produces a result while none was pending
  a_edge_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i == dcd_pkg::ACT_ADD) && !out_valid_o
    |=> !out_valid_o)
    else $error("edge item produced a result");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(has_cycle_o))
    else $error("stalled result changed");

endmodule

bind directed_cycle_detect_top dcd_checker u_dcd_checker (.*);

// ===== tb/dcd_checker.sv =====
// ----------------------------------------------------------------------------
// dcd_tb_checker
// Watches the config write, input and output channels of the directed cycle
// detector. It keeps its own adjacency matrix and vertex count, runs the
// depth-first cycle search on every accepted evaluate item, queues the
// expected has_cycle flag and compares each accepted result against it.
// ----------------------------------------------------------------------------
module dcd_tb_checker #(
  parameter int NV = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dcd_pkg::VCOUNT_W-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         action_i,
  input  logic [dcd_pkg::VID_W-1:0]    from_vertex_i,
  input  logic [dcd_pkg::VID_W-1:0]    to_vertex_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic                         has_cycle_i,
  output int                           fail_count_o,
  output int                           due_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DUE_DEPTH = 4;

  logic [NV-1:0]                adj_rows [NV];
  logic [dcd_pkg::VCOUNT_W-1:0] vcount;
  logic                         flags_due [DUE_DEPTH];
  int                           rd_ptr = 0;
  int                           wr_ptr = 0;
  int                           fails = 0;
  int                           due = 0;

  assign fail_count_o = fails;
  assign due_count_o  = due;

  // Iterative DFS with an explicit stack; the top vertex is rescanned after
  // every push and a neighbor on the current path means a cycle.
  function automatic logic graph_has_cycle();
    int            n;
    int            depth;
    int            top;
    int            nxt;
    int            stack [NV];
    logic          have_next;
    logic          cyc;
    logic [NV-1:0] seen;
    logic [NV-1:0] on_path;
    n       = (vcount > NV) ? NV : int'(vcount);
    seen    = '0;
    on_path = '0;
    depth   = 0;
    cyc     = 1'b0;
    for (int s = 0; s < n && !cyc; s++) begin
      if (seen[s]) continue;
      stack[0]   = s;
      depth      = 1;
      seen[s]    = 1'b1;
      on_path[s] = 1'b1;
      while (depth > 0 && !cyc) begin
        top       = stack[depth-1];
        nxt       = 0;
        have_next = 1'b0;
        for (int u = 0; u < n; u++) begin
          if (!adj_rows[top][u]) continue;
          if (on_path[u]) begin
            cyc = 1'b1;
            break;
          end
          if (!have_next && !seen[u]) begin
            nxt       = u;
            have_next = 1'b1;
          end
        end
        if (!cyc) begin
          if (have_next) begin
            if (depth < NV) begin
              stack[depth]  = nxt;
              depth++;
              seen[nxt]     = 1'b1;
              on_path[nxt]  = 1'b1;
            end
          end else begin
            on_path[top] = 1'b0;
            depth--;
          end
        end
      end
    end
    return cyc;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic want;
    if (!rst_ni) begin
      foreach (adj_rows[r]) adj_rows[r] = '0;
      vcount = dcd_pkg::VCOUNT_RESET;
      rd_ptr = 0;
      wr_ptr = 0;
      due    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due == 0) begin
          $error("has_cycle: no item expected, actual %0b", has_cycle_i);
          fails++;
        end else begin
          want   = flags_due[rd_ptr];
          rd_ptr = (rd_ptr + 1) % DUE_DEPTH;
          due--;
          if (has_cycle_i !== want) begin
            $error("has_cycle: expected %0b, actual %0b", want, has_cycle_i);
            fails++;
          end
        end
      end
      if (cfg_we_i) vcount = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        if (action_i == dcd_pkg::ACT_ADD) begin
          adj_rows[from_vertex_i][to_vertex_i] = 1'b1;
        end else begin
          if (due == DUE_DEPTH) begin
            $error("has_cycle: too many items outstanding, count %0d", due);
            fails++;
          end else begin
            flags_due[wr_ptr] = graph_has_cycle();
            wr_ptr = (wr_ptr + 1) % DUE_DEPTH;
            due++;
          end
          foreach (adj_rows[r]) adj_rows[r] = '0;
        end
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the directed cycle detector. A short directed set
// of graphs (self loops, extreme vertices, duplicate and ignored edges) is
// followed by random graphs (acyclic, acyclic with a back edge, chains with
// and without a closing edge, random edges, noise) over several vertex
// counts. Both channels idle in random bursts; the result side holds off once
// for a long stretch so the block backs up. dcd_tb_checker does the checking.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV           = 64;
  localparam int HALF_PERIOD  = 6;
  localparam int SETTLE       = 8;
  localparam int DRAIN        = 5 * NV + 3;
  localparam int LONG_HOLD    = 400;
  localparam int PHASE_ITEMS  = 125;
  localparam int NUM_PHASES   = 11;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [dcd_pkg::VCOUNT_W-1:0] cfg_wdata_i;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic                         action_i;
  logic [dcd_pkg::VID_W-1:0]    from_vertex_i;
  logic [dcd_pkg::VID_W-1:0]    to_vertex_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic                         has_cycle_o;

  int fail_count;
  int due_count;
  int results_taken = 0;
  int items_offered = 0;
  bit calm = 1'b0;

  directed_cycle_detect_top #(
    .MAX_VERTICES(NV)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .from_vertex_i (from_vertex_i),
    .to_vertex_i   (to_vertex_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .has_cycle_o   (has_cycle_o)
  );

  dcd_tb_checker #(
    .NV(NV)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .action_i      (action_i),
    .from_vertex_i (from_vertex_i),
    .to_vertex_i   (to_vertex_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .has_cycle_i   (has_cycle_o),
    .fail_count_o  (fail_count),
    .due_count_o   (due_count)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) results_taken++;
  end

  task automatic offer(input logic act, input int f, input int t);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    from_vertex_i <= dcd_pkg::VID_W'(f);
    to_vertex_i   <= dcd_pkg::VID_W'(t);
    do @(posedge clk_i); while (in_stall_o);
    items_offered++;
    @(negedge clk_i);
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (due_count != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_count(input int vc);
    cfg_wdata_i <= dcd_pkg::VCOUNT_W'(vc);
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // One edge set followed by an evaluate.
  task automatic random_graph(input int vc);
    int n;
    int shape;
    int num_edges;
    int a;
    int b;
    int k;
    int j;
    int tmp;
    int order [NV];
    n         = (vc > NV) ? NV : vc;
    shape     = (n < 2) ? 3 : $urandom_range(0, 4);
    num_edges = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
    if (shape == 4) begin
      for (int i = 0; i < n; i++) order[i] = i;
      for (int i = n - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      k = ($urandom_range(0, 7) == 0) ? n - 1 : $urandom_range(1, (n - 1 < 10) ? n - 1 : 10);
      for (int i = 0; i < k; i++) offer(dcd_pkg::ACT_ADD, order[i], order[i+1]);
      if ($urandom_range(0, 1) == 1) begin
        offer(dcd_pkg::ACT_ADD, order[k], order[$urandom_range(0, k)]);
      end
    end else begin
      for (int e = 0; e < num_edges; e++) begin
        if (n == 0 || $urandom_range(0, 9) == 0) begin
          offer(dcd_pkg::ACT_ADD, $urandom_range(0, NV - 1), $urandom_range(0, NV - 1));
          continue;
        end
        a = $urandom_range(0, n - 1);
        b = $urandom_range(0, n - 1);
        if (shape <= 1) begin
          if (a == b) continue;
          if (a > b) offer(dcd_pkg::ACT_ADD, b, a);
          else offer(dcd_pkg::ACT_ADD, a, b);
        end else begin
          offer(dcd_pkg::ACT_ADD, a, b);
        end
      end
      if (shape == 1) begin
        a = $urandom_range(0, n - 2);
        b = $urandom_range(a + 1, n - 1);
        offer(dcd_pkg::ACT_ADD, b, a);
      end
    end
    offer(dcd_pkg::ACT_EVAL, $urandom_range(0, NV - 1), $urandom_range(0, NV - 1));
  endtask

  // Result side: random stall bursts, plus one long hold-off.
  initial begin
    bit held;
    held        = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && results_taken >= 40) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
        held = 1'b1;
        out_stall_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int phase_counts [NUM_PHASES];
    int goal;
    phase_counts  = '{2, 0, 127, 1, 64, 65, 3, 8, 17, 40, 64};
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    action_i      = dcd_pkg::ACT_ADD;
    from_vertex_i = '0;
    to_vertex_i   = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset count of 64: empty graph, self loops, extreme vertices, duplicates
    offer(dcd_pkg::ACT_EVAL, NV - 1, NV - 1);
    offer(dcd_pkg::ACT_ADD, 0, 0);
    offer(dcd_pkg::ACT_EVAL, 0, 0);
    offer(dcd_pkg::ACT_ADD, NV - 1, NV - 1);
    offer(dcd_pkg::ACT_EVAL, 0, 0);
    offer(dcd_pkg::ACT_ADD, 0, NV - 1);
    offer(dcd_pkg::ACT_ADD, NV - 1, 0);
    offer(dcd_pkg::ACT_EVAL, 0, 0);
    offer(dcd_pkg::ACT_ADD, 0, 1);
    offer(dcd_pkg::ACT_ADD, 1, 2);
    offer(dcd_pkg::ACT_ADD, 1, 2);
    offer(dcd_pkg::ACT_ADD, 2, NV - 1);
    offer(dcd_pkg::ACT_EVAL, 21, 42);
    offer(dcd_pkg::ACT_ADD, 21, 42);
    offer(dcd_pkg::ACT_ADD, 42, 21);
    offer(dcd_pkg::ACT_EVAL, 42, 21);
    quiesce();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_count(phase_counts[p]);
      if (p == NUM_PHASES - 1) calm = 1'b1;
      if (phase_counts[p] == 2) begin
        // edges touching a vertex past the count are ignored
        offer(dcd_pkg::ACT_ADD, 0, 1);
        offer(dcd_pkg::ACT_ADD, 1, 5);
        offer(dcd_pkg::ACT_ADD, 5, 0);
        offer(dcd_pkg::ACT_EVAL, 0, 0);
        offer(dcd_pkg::ACT_ADD, 1, 1);
        offer(dcd_pkg::ACT_EVAL, 0, 0);
      end else if (phase_counts[p] == 0) begin
        offer(dcd_pkg::ACT_ADD, 0, 0);
        offer(dcd_pkg::ACT_EVAL, 0, 0);
      end
      goal = items_offered + PHASE_ITEMS;
      while (items_offered < goal) random_graph(phase_counts[p]);
      quiesce();
    end

    repeat (DRAIN) @(negedge clk_i);
    if (fail_count == 0 && due_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
